// ===== sv/tcw_pkg.sv =====
// Shared types, register codes and the log mantissa table for the spline warp.
package tcw_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int COORD_BITS = 12;
    localparam int DIST_BITS  = 2 * COORD_BITS + 1;
    localparam int POS_BITS   = $clog2(DIST_BITS);
    localparam int LN_BITS    = 21;
    localparam int ACC_BITS   = 48;
    localparam logic [15:0] LN2_Q16 = 16'd45426;

    localparam logic [2:0] REG_X_OFFSET  = 3'd0;
    localparam logic [2:0] REG_X_GAIN_X  = 3'd1;
    localparam logic [2:0] REG_X_GAIN_Y  = 3'd2;
    localparam logic [2:0] REG_Y_OFFSET  = 3'd3;
    localparam logic [2:0] REG_Y_GAIN_X  = 3'd4;
    localparam logic [2:0] REG_Y_GAIN_Y  = 3'd5;
    localparam logic [2:0] REG_ACTIVE    = 3'd6;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    typedef struct packed {
        logic                         req_type;
        logic [5:0]                   point_index;
        logic [COORD_BITS-1:0]        point_x;
        logic [COORD_BITS-1:0]        point_y;
        logic signed [31:0]           weight_x;
        logic signed [31:0]           weight_y;
        logic [COORD_BITS-1:0]        pixel_x;
        logic [COORD_BITS-1:0]        pixel_y;
    } req_t;

    typedef struct packed {
        logic signed [31:0] mapped_x;
        logic signed [31:0] mapped_y;
    } rsp_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [31:0]           wx;
        logic [31:0]           wy;
    } point_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_A0, ST_A1, ST_A2, ST_A3, ST_A4,
        ST_RD, ST_SX, ST_SY, ST_SD, ST_SL, ST_SU,
        ST_W0, ST_W1, ST_W2, ST_W3, ST_W4, ST_FIN
    } tcw_state_t;

    typedef logic [15:0] ln_tab_t [64];

    function automatic logic [63:0] const_div(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b})
            begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic ln_tab_t build_ln_tab();
        ln_tab_t     t;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] n;
        logic [63:0] r;
        for (int k = 0; k < 64; k++)
        begin
            z    = const_div(64'(k) << 32, 64'd128 + 64'(k));
            z2   = (z * z) >> 32;
            term = z;
            sum  = 64'd0;
            n    = 64'd1;
            for (int i = 0; i < 40; i++)
            begin
                if (term != 64'd0)
                begin
                    sum  = sum + const_div(term, n);
                    term = (term * z2) >> 32;
                    n    = n + 64'd2;
                end
            end
            r    = (64'd2 * sum + 64'd32768) >> 16;
            t[k] = r[15:0];
        end
        return t;
    endfunction

    localparam ln_tab_t LN_TAB = build_ln_tab();

endpackage

// ===== sv/tcw_ifs.sv =====
// Valid/ready channel interfaces for request and response beats.
interface tcw_req_if;
    import tcw_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tcw_rsp_if;
    import tcw_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tcw_point_mem.sv =====
// Control point table: one write port, one registered read port.
module tcw_point_mem (
    input  logic                          clk,
    input  logic                          we,
    input  logic [tcw_pkg::IDX_BITS-1:0]  waddr,
    input  tcw_pkg::point_t               wdata,
    input  logic [tcw_pkg::IDX_BITS-1:0]  raddr,
    output tcw_pkg::point_t               rdata
);
    import tcw_pkg::*;

    point_t mem [MAX_POINTS];
    point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/tcw_ln_unit.sv =====
// Fixed-point natural log of the squared distance: leading one plus mantissa table.
module tcw_ln_unit (
    input  logic [tcw_pkg::DIST_BITS-1:0] d,
    output logic [tcw_pkg::LN_BITS-1:0]   ln
);
    import tcw_pkg::*;

    logic [POS_BITS-1:0]  pos;
    logic [DIST_BITS-1:0] norm;
    logic [5:0]           k;

    always_comb
    begin
        pos = '0;
        for (int i = 1; i < DIST_BITS; i++)
        begin
            if (d[i])
            begin
                pos = POS_BITS'(i);
            end
        end
        norm = d << (POS_BITS'(DIST_BITS - 1) - pos);
        k    = norm[DIST_BITS-2 -: 6];
        ln   = LN_BITS'(pos) * LN_BITS'(LN2_Q16) + LN_BITS'(LN_TAB[k]);
    end
endmodule

// ===== sv/tcw_coordinate_warp.sv =====
// Top level: sequencer, shared multiplier and accumulators of the spline warp.
// Load beat: written to the point table on accept, no response.
// Map beat: after accept the sequencer runs the affine states, then the per-point states for each
// of N = active points (max 64), then waits in finish while the previous response is still held.
// One map in the datapath; the shared 33x33 multiplier serialises the steps of each point.
// Reset: identity affine, zero active points; point table undefined until loaded.
module tps_coordinate_warp (
    input  logic        clk,
    input  logic        rst_n,
    tcw_req_if.sink     req,
    tcw_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tcw_pkg::*;

    tcw_state_t state_reg, state_next;

    logic signed [31:0] x_off_reg, x_gx_reg, x_gy_reg;
    logic signed [31:0] y_off_reg, y_gx_reg, y_gy_reg;
    logic [6:0]         active_reg;

    logic [COORD_BITS-1:0]      px_reg, py_reg;
    logic [CNT_BITS-1:0]        n_reg, idx_reg;
    logic signed [ACC_BITS-1:0] acc_x_reg, acc_y_reg;
    logic [DIST_BITS-1:0]       d_reg;
    logic [LN_BITS-1:0]         ln_reg;
    logic [45:0]                u_reg;
    logic [54:0]                plo_reg;
    logic signed [65:0]         prod_reg;
    logic                       out_valid_reg;
    rsp_t                       out_reg;

    logic signed [32:0] mul_a, mul_b;
    point_t             pt;
    point_t             wr_pt;
    logic [LN_BITS-1:0] ln_val;
    logic               accept;
    logic signed [13:0] dx, dy;
    logic [32:0]        mag_x, mag_y;
    logic [78:0]        full;
    logic [ACC_BITS-1:0] term;
    logic signed [ACC_BITS-5:0] res_x, res_y;
    logic [CNT_BITS-1:0] idx_inc;

    assign accept = req.valid && req.ready;

    assign wr_pt.cx = req.data.point_x;
    assign wr_pt.cy = req.data.point_y;
    assign wr_pt.wx = req.data.weight_x;
    assign wr_pt.wy = req.data.weight_y;

    tcw_point_mem u_mem (
        .clk   (clk),
        .we    (accept && req.data.req_type == REQ_LOAD),
        .waddr (req.data.point_index[IDX_BITS-1:0]),
        .wdata (wr_pt),
        .raddr (idx_reg[IDX_BITS-1:0]),
        .rdata (pt)
    );

    tcw_ln_unit u_ln (
        .d  (d_reg),
        .ln (ln_val)
    );

    assign dx      = $signed({2'b00, px_reg}) - $signed({2'b00, pt.cx});
    assign dy      = $signed({2'b00, py_reg}) - $signed({2'b00, pt.cy});
    assign mag_x   = pt.wx[31] ? (33'd0 - {1'b1, pt.wx}) : {1'b0, pt.wx};
    assign mag_y   = pt.wy[31] ? (33'd0 - {1'b1, pt.wy}) : {1'b0, pt.wy};
    assign full    = {prod_reg[55:0], 23'd0} + {24'd0, plo_reg};
    assign term    = {9'd0, full[78:40]};
    assign idx_inc = idx_reg + 1'b1;
    assign res_x   = acc_x_reg[ACC_BITS-1:4];
    assign res_y   = acc_y_reg[ACC_BITS-1:4];

    function automatic logic [31:0] sat32(input logic signed [ACC_BITS-5:0] v);
        logic [31:0] r;
        if (v > $signed(45'sd2147483647))
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -$signed(45'sd2147483648))
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.data.req_type == REQ_MAP)
                begin
                    state_next = ST_A0;
                end
            end
            ST_A0: state_next = ST_A1;
            ST_A1: state_next = ST_A2;
            ST_A2: state_next = ST_A3;
            ST_A3: state_next = ST_A4;
            ST_A4: state_next = (n_reg == '0) ? ST_FIN : ST_RD;
            ST_RD: state_next = ST_SX;
            ST_SX: state_next = ST_SY;
            ST_SY: state_next = ST_SD;
            ST_SD: state_next = ST_SL;
            ST_SL: state_next = ST_SU;
            ST_SU: state_next = ST_W0;
            ST_W0: state_next = ST_W1;
            ST_W1: state_next = ST_W2;
            ST_W2: state_next = ST_W3;
            ST_W3: state_next = ST_W4;
            ST_W4: state_next = (idx_inc == n_reg) ? ST_FIN : ST_RD;
            ST_FIN: state_next = out_valid_reg ? ST_FIN : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        req.ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_A0:
            begin
                mul_a = {x_gx_reg[31], x_gx_reg};
                mul_b = {21'd0, px_reg};
            end
            ST_A1:
            begin
                mul_a = {x_gy_reg[31], x_gy_reg};
                mul_b = {21'd0, py_reg};
            end
            ST_A2:
            begin
                mul_a = {y_gx_reg[31], y_gx_reg};
                mul_b = {21'd0, px_reg};
            end
            ST_A3:
            begin
                mul_a = {y_gy_reg[31], y_gy_reg};
                mul_b = {21'd0, py_reg};
            end
            ST_SX:
            begin
                mul_a = 33'(dx);
                mul_b = 33'(dx);
            end
            ST_SY:
            begin
                mul_a = 33'(dy);
                mul_b = 33'(dy);
            end
            ST_SU:
            begin
                mul_a = {8'd0, d_reg};
                mul_b = {12'd0, ln_reg};
            end
            ST_W0:
            begin
                mul_a = {10'd0, prod_reg[22:0]};
                mul_b = mag_x;
            end
            ST_W1:
            begin
                mul_a = {10'd0, u_reg[45:23]};
                mul_b = mag_x;
            end
            ST_W2:
            begin
                mul_a = {10'd0, u_reg[22:0]};
                mul_b = mag_y;
            end
            ST_W3:
            begin
                mul_a = {10'd0, u_reg[45:23]};
                mul_b = mag_y;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            x_off_reg     <= '0;
            x_gx_reg      <= 32'sd65536;
            x_gy_reg      <= '0;
            y_off_reg     <= '0;
            y_gx_reg      <= '0;
            y_gy_reg      <= 32'sd65536;
            active_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_X_OFFSET: x_off_reg  <= cfg_data;
                    REG_X_GAIN_X: x_gx_reg   <= cfg_data;
                    REG_X_GAIN_Y: x_gy_reg   <= cfg_data;
                    REG_Y_OFFSET: y_off_reg  <= cfg_data;
                    REG_Y_GAIN_X: y_gx_reg   <= cfg_data;
                    REG_Y_GAIN_Y: y_gy_reg   <= cfg_data;
                    REG_ACTIVE:   active_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                px_reg    <= req.data.pixel_x;
                py_reg    <= req.data.pixel_y;
                idx_reg   <= '0;
                n_reg     <= (active_reg > 7'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS)
                                                           : CNT_BITS'(active_reg);
                acc_x_reg <= {{(ACC_BITS-36){x_off_reg[31]}}, x_off_reg, 4'd0};
                acc_y_reg <= {{(ACC_BITS-36){y_off_reg[31]}}, y_off_reg, 4'd0};
            end
            ST_A1: acc_x_reg <= acc_x_reg + ACC_BITS'(prod_reg);
            ST_A2: acc_x_reg <= acc_x_reg + ACC_BITS'(prod_reg);
            ST_A3: acc_y_reg <= acc_y_reg + ACC_BITS'(prod_reg);
            ST_A4: acc_y_reg <= acc_y_reg + ACC_BITS'(prod_reg);
            ST_SY: d_reg <= prod_reg[DIST_BITS-1:0];
            ST_SD: d_reg <= d_reg + prod_reg[DIST_BITS-1:0];
            ST_SL: ln_reg <= ln_val;
            ST_W0: u_reg <= prod_reg[45:0];
            ST_W1: plo_reg <= prod_reg[54:0];
            ST_W2:
            begin
                if (d_reg != '0)
                begin
                    acc_x_reg <= pt.wx[31] ? acc_x_reg - $signed(term)
                                           : acc_x_reg + $signed(term);
                end
            end
            ST_W3: plo_reg <= prod_reg[54:0];
            ST_W4:
            begin
                idx_reg <= idx_inc;
                if (d_reg != '0)
                begin
                    acc_y_reg <= pt.wy[31] ? acc_y_reg - $signed(term)
                                           : acc_y_reg + $signed(term);
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg)
                begin
                    out_reg.mapped_x <= sat32(res_x);
                    out_reg.mapped_y <= sat32(res_y);
                end
            end
            default: ;
        endcase
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("response raised outside finish");
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (idx_reg < n_reg))
        else $error("point index past active count");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (state_reg == ST_IDLE))
        else $error("ready while busy");
    a_map_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.data.req_type == REQ_MAP) |=> (state_reg == ST_A0))
        else $error("map beat did not start sequence");
endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the thin-plate-spline coordinate warp.
module testbench;
    import tcw_pkg::*;

    localparam int REQ_W = $bits(req_t);

    typedef enum logic [1:0] { ROW_LOAD, ROW_MAP, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        req_t        beat;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        bit          known;
        rsp_t        want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    tcw_req_if req_ch();
    tcw_rsp_if rsp_ch();

    tps_coordinate_warp uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    logic [15:0]        ln_mant [64];
    logic [11:0]        pt_x [64];
    logic [11:0]        pt_y [64];
    logic signed [31:0] pt_wx [64];
    logic signed [31:0] pt_wy [64];
    logic signed [31:0] off_x, gain_xx, gain_xy, off_y, gain_yx, gain_yy;
    logic [6:0]         n_active;

    rsp_t      mapped_q [$];
    stim_row_t rows [$];
    int        fails = 0;
    int        idle_cycles = 0;
    bit        quiet = 0;
    bit        hold_req = 0;
    bit        hold_done = 0;

    function automatic longint unsigned ln_q16(longint unsigned d);
        int p;
        int k;
        p = 0;
        while (p < 62 && (d >> (p + 1)) != 0)
            p++;
        if (p >= 6)
            k = int'((d >> (p - 6)) & 64'd63);
        else
            k = int'((d << (6 - p)) & 64'd63);
        return longint'(p) * 45426 + ln_mant[k];
    endfunction

    function automatic longint weighted(longint unsigned u, logic signed [31:0] w);
        logic [127:0]    prod;
        longint unsigned mag;
        longint          q;
        mag  = (w < 0) ? longint'(-longint'(w)) : longint'(w);
        prod = {64'd0, u} * {64'd0, mag};
        q    = longint'(prod >> 40);
        return (w < 0) ? -q : q;
    endfunction

    function automatic logic signed [31:0] saturate(longint acc);
        longint r;
        r = acc >>> 4;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic rsp_t warp_pixel(logic [11:0] px, logic [11:0] py);
        longint          ax;
        longint          ay;
        longint          dx;
        longint          dy;
        longint unsigned d;
        longint unsigned u;
        int              n;
        rsp_t            r;
        ax = longint'(off_x) * 16 + longint'(gain_xx) * longint'(px)
           + longint'(gain_xy) * longint'(py);
        ay = longint'(off_y) * 16 + longint'(gain_yx) * longint'(px)
           + longint'(gain_yy) * longint'(py);
        n = (n_active > MAX_POINTS) ? MAX_POINTS : int'(n_active);
        for (int i = 0; i < n; i++)
        begin
            dx = longint'(px) - longint'(pt_x[i]);
            dy = longint'(py) - longint'(pt_y[i]);
            d  = dx * dx + dy * dy;
            if (d != 0)
            begin
                u  = d * ln_q16(d);
                ax = ax + weighted(u, pt_wx[i]);
                ay = ay + weighted(u, pt_wy[i]);
            end
        end
        r.mapped_x = saturate(ax);
        r.mapped_y = saturate(ay);
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t rand_req();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[REQ_W-1:0];
    endfunction

    function automatic stim_row_t ld(int idx, int x, int y, logic [31:0] wx, logic [31:0] wy);
        stim_row_t r;
        r = '{kind: ROW_LOAD, default: '0};
        r.kind = ROW_LOAD;
        r.beat = rand_req();
        r.beat.req_type = REQ_LOAD;
        r.beat.point_index = 6'(idx);
        r.beat.point_x = 12'(x);
        r.beat.point_y = 12'(y);
        r.beat.weight_x = wx;
        r.beat.weight_y = wy;
        return r;
    endfunction

    function automatic stim_row_t mp(int x, int y, bit known, logic [31:0] ex, logic [31:0] ey);
        stim_row_t r;
        r = '{kind: ROW_MAP, default: '0};
        r.kind = ROW_MAP;
        r.beat = rand_req();
        r.beat.req_type = REQ_MAP;
        r.beat.pixel_x = 12'(x);
        r.beat.pixel_y = 12'(y);
        r.known = known;
        r.want.mapped_x = ex;
        r.want.mapped_y = ey;
        return r;
    endfunction

    function automatic stim_row_t cf(logic [2:0] idx, logic [31:0] val);
        stim_row_t r;
        r = '{kind: ROW_CFG, default: '0};
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_X_OFFSET: off_x    = val;
            REG_X_GAIN_X: gain_xx  = val;
            REG_X_GAIN_Y: gain_xy  = val;
            REG_Y_OFFSET: off_y    = val;
            REG_Y_GAIN_X: gain_yx  = val;
            REG_Y_GAIN_Y: gain_yy  = val;
            REG_ACTIVE:   n_active = val[6:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (mapped_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_beat(req_t it, bit known, rsp_t want);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (it.req_type == REQ_LOAD)
        begin
            pt_x[it.point_index]  = it.point_x;
            pt_y[it.point_index]  = it.point_y;
            pt_wx[it.point_index] = it.weight_x;
            pt_wy[it.point_index] = it.weight_y;
        end
        else
            mapped_q.push_back(known ? want : warp_pixel(it.pixel_x, it.pixel_y));
    endtask

    initial
    begin
        logic [63:0] z, z2, term, sum, n;
        for (int k = 0; k < 64; k++)
        begin
            z    = (64'(k) << 32) / (64'd128 + 64'(k));
            z2   = (z * z) >> 32;
            term = z;
            sum  = 0;
            n    = 1;
            while (term != 0 && n < 1000)
            begin
                sum  = sum + term / n;
                term = (term * z2) >> 32;
                n    = n + 2;
            end
            ln_mant[k] = 16'((2 * sum + 64'd32768) >> 16);
        end
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_done = 1;
            end
            else if (quiet || $urandom_range(0, 3) != 0)
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (mapped_q.size() == 0)
            begin
                $error("unexpected response beat %h", rsp_ch.data);
                fails++;
            end
            else
            begin
                exp_rsp = mapped_q.pop_front();
                if (rsp_ch.data.mapped_x !== exp_rsp.mapped_x)
                begin
                    $error("mapped_x expected %h actual %h",
                           exp_rsp.mapped_x, rsp_ch.data.mapped_x);
                    fails++;
                end
                if (rsp_ch.data.mapped_y !== exp_rsp.mapped_y)
                begin
                    $error("mapped_y expected %h actual %h",
                           exp_rsp.mapped_y, rsp_ch.data.mapped_y);
                    fails++;
                end
            end
        end
        if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 20000)
        begin
            $display("[tps_coordinate_warp] ERROR");
            $finish;
        end
    end

    initial
    begin
        req_t      it;
        rsp_t      none;
        stim_row_t r;
        int        n;
        int        j;
        none = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        off_x = 0; gain_xx = 65536; gain_xy = 0;
        off_y = 0; gain_yx = 0; gain_yy = 65536;
        n_active = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(mp(0, 0, 1, 0, 0));
        rows.push_back(mp(4095, 4095, 1, 32'd16773120, 32'd16773120));
        rows.push_back(mp(4095, 0, 1, 32'd16773120, 0));
        rows.push_back(cf(REG_X_GAIN_X, 32'h7FFF_FFFF));
        rows.push_back(cf(REG_Y_GAIN_Y, 32'h8000_0000));
        rows.push_back(mp(4095, 4095, 1, 32'h7FFF_FFFF, 32'h8000_0000));
        rows.push_back(cf(REG_X_GAIN_X, 32'd65536));
        rows.push_back(cf(REG_Y_GAIN_Y, 32'd65536));
        rows.push_back(cf(REG_X_OFFSET, 32'h8000_0000));
        rows.push_back(cf(REG_Y_OFFSET, 32'h7FFF_FFFF));
        rows.push_back(mp(0, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF));
        rows.push_back(cf(REG_X_OFFSET, 0));
        rows.push_back(cf(REG_Y_OFFSET, 0));
        rows.push_back(ld(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        rows.push_back(ld(1, 4095, 4095, 32'hFFFF_FFFF, 32'd1));
        rows.push_back(ld(2, 100, 200, 32'h1234_5678, -32'sd5));
        rows.push_back(ld(3, 10, 10, 0, 32'h0000_8000));
        rows.push_back(ld(63, 4095, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        rows.push_back(cf(REG_ACTIVE, 4));
        rows.push_back(mp(0, 0, 0, 0, 0));
        rows.push_back(mp(4095, 4095, 0, 0, 0));
        rows.push_back(mp(100, 200, 0, 0, 0));
        rows.push_back(mp(4095, 0, 0, 0, 0));
        rows.push_back(mp(0, 4095, 0, 0, 0));

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.kind == ROW_CFG)
            begin
                drain();
                cfg_write(r.reg_idx, r.reg_val);
                cfg_we <= 1'b0;
            end
            else
                send_beat(r.beat, r.known, r.want);
        end

        for (int s = 0; s < 64; s++)
        begin
            it = rand_req();
            it.req_type = REQ_LOAD;
            it.point_index = 6'(s);
            it.weight_x = rand_word();
            it.weight_y = rand_word();
            send_beat(it, 0, none);
        end

        for (int ph = 0; ph < 13; ph++)
        begin
            drain();
            if (ph == 12)
                quiet = 1;
            cfg_write(REG_X_OFFSET, rand_word());
            cfg_write(REG_Y_OFFSET, rand_word());
            cfg_write(REG_X_GAIN_X, rand_word());
            cfg_write(REG_X_GAIN_Y, rand_word());
            cfg_write(REG_Y_GAIN_X, rand_word());
            cfg_write(REG_Y_GAIN_Y, rand_word());
            if (ph == 3 || ph == 10)
                cfg_write(REG_ACTIVE, 64);
            else if (ph == 7)
                cfg_write(REG_ACTIVE, 127);
            else
                cfg_write(REG_ACTIVE, $urandom_range(0, 8));
            cfg_we <= 1'b0;
            if (ph == 2)
                hold_req = 1;
            n = (n_active > MAX_POINTS) ? MAX_POINTS : int'(n_active);
            for (int k = 0; k < 66; k++)
            begin
                if (ph == 5 && k == 30)
                begin
                    req_ch.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (mapped_q.size() != 0);
                end
                it = rand_req();
                it.weight_x = rand_word();
                it.weight_y = rand_word();
                it.req_type = ($urandom_range(0, 9) < 3) ? REQ_LOAD : REQ_MAP;
                if (it.req_type == REQ_MAP && n > 0 && $urandom_range(0, 5) == 0)
                begin
                    j = $urandom_range(0, n - 1);
                    it.pixel_x = pt_x[j];
                    it.pixel_y = pt_y[j];
                end
                send_beat(it, 0, none);
            end
        end

        req_ch.valid <= 1'b0;
        while (mapped_q.size() != 0)
            @(posedge clk);
        repeat (800) @(posedge clk);
        if (fails == 0)
            $display("[tps_coordinate_warp] OK");
        else
            $display("[tps_coordinate_warp] ERROR");
        $finish;
    end

endmodule
